[src/bmpc_pkg.sv]
package bmpc_pkg;

  localparam int MaxBones = 256;
  localparam int FracBits = 16;
  localparam int BoneW = $clog2(MaxBones);
  localparam int StoreDepth = MaxBones * 12;
  localparam int StoreAw = $clog2(StoreDepth);

  typedef enum logic [1:0] {
    ActBase   = 2'd0,
    ActLocal  = 2'd1,
    ActOffset = 2'd2,
    ActScale  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMac,
    StOffset,
    StStore,
    StEmit
  } state_e;

  function automatic logic signed [63:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = a * b;
      fx_mul = p >>> FracBits;
    end
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    begin
      if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

endpackage

[src/bmpc_mac.sv]
module bmpc_mac (
  input  logic                clk_i,
  input  logic                clr_i,
  input  logic                en_i,
  input  logic signed [31:0]  init_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  output logic signed [63:0]  prod_o,
  output logic signed [65:0]  acc_o
);
  import bmpc_pkg::*;

  logic signed [65:0] acc_q, acc_d;

  assign prod_o = fx_mul(a_i, b_i);

  always_comb begin
    acc_d = clr_i ? 66'(init_i) : acc_q;
    if (en_i) acc_d = acc_d + 66'(prod_o);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule

[src/bone_matrix_palette_compose_unit.sv]
// Bone matrix palette composer.
// Input channel (valid_i/stall_o): one item per row or control vector.
// action 0 loads a base matrix row, 2 and 3 latch offset and scale vectors,
// 1 carries a bone local row; row 3 of a bone triggers composition.
// Output channel (valid_o/stall_i): four items per bone, rows 0..3,
// last_row marks row 3.
// Other items do not raise stall_o. A trigger item keeps stall_o high while
// the unit copies a non-root parent global from the store, computes the 12
// global elements (three multiply-accumulates and a commit each) on one
// shared multiply-accumulate unit, computes the offset row when pending,
// writes the 12 elements to the store, then emits the rows, rows 0..2 each
// scaled through the same multiplier when a scale is pending; emit waits on
// stall_i, and no new item is taken meanwhile.
// The parent global store has one write port and one registered read port, read one element a cycle.
// Reset restores the identity base and clears pending flags; the global
// store is not cleared and must be written before use as a parent.
module bone_matrix_palette_compose_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic [1:0]          action_i,
  input  logic [7:0]          bone_index_i,
  input  logic signed [8:0]   parent_index_i,
  input  logic [1:0]          row_index_i,
  input  logic signed [31:0]  elem_x_i,
  input  logic signed [31:0]  elem_y_i,
  input  logic signed [31:0]  elem_z_i,
  output logic                valid_o,
  input  logic                stall_i,
  output logic [7:0]          out_bone_o,
  output logic [1:0]          out_row_o,
  output logic signed [31:0]  out_x_o,
  output logic signed [31:0]  out_y_o,
  output logic signed [31:0]  out_z_o,
  output logic                last_row_o
);
  import bmpc_pkg::*;

  state_e state_q, state_d;
  logic signed [31:0] base_q [12];
  logic signed [31:0] loc_q [12];
  logic signed [31:0] par_q [12];
  logic signed [31:0] g_q [12];
  logic signed [31:0] off_q [3], scl_q [3];
  logic off_pend_q, scl_pend_q, store_ok_q;
  logic [7:0] bone_q;
  logic [BoneW-1:0] par_idx_q;
  logic [3:0] ei_q;
  logic [1:0] k_q;
  logic       rd_pend_q;
  logic signed [31:0] mem [StoreDepth];
  logic signed [31:0] rd_q;
  logic [1:0] orow_q;
  logic [1:0] oc_q;

  logic mac_clr, mac_en;
  logic signed [31:0] mac_init, mac_a, mac_b;
  logic signed [63:0] mac_prod;
  logic signed [65:0] acc;

  bmpc_mac u_mac (
    .clk_i, .clr_i(mac_clr), .en_i(mac_en), .init_i(mac_init),
    .a_i(mac_a), .b_i(mac_b), .prod_o(mac_prod), .acc_o(acc)
  );

  logic acc_in;
  assign acc_in = valid_i && !stall_o;
  assign stall_o = (state_q != StIdle);

  logic [1:0] er, ec;
  assign er = (ei_q >= 4'd9) ? 2'd3 : (ei_q >= 4'd6) ? 2'd2 : (ei_q >= 4'd3) ? 2'd1 : 2'd0;
  assign ec = 2'(ei_q - ({er, 2'b00} - {2'b00, er}));

  logic [3:0] ki_par;
  assign ki_par = 4'({2'b0, k_q} * 3 + {2'b0, ec});

  logic [StoreAw-1:0] waddr, raddr;
  assign waddr = StoreAw'(bone_q[BoneW-1:0] * 12 + ei_q);
  assign raddr = StoreAw'(par_idx_q * 12 + ei_q);

  logic is_root;
  assign is_root = parent_index_i[8] || (parent_index_i[7:0] >= bone_index_i);

  always_ff @(posedge clk_i) begin
    if (state_q == StStore && store_ok_q) mem[waddr] <= g_q[ei_q];
    rd_q <= mem[raddr];
  end

  // Sequencing: StLoad copies the parent into par_q via the registered read port,
  // StMac does k=0..2 per element then commits, StOffset likewise for row 3.
  always_comb begin
    state_d = state_q;
    mac_clr = 1'b0;
    mac_en = 1'b0;
    mac_init = '0;
    mac_a = '0;
    mac_b = '0;
    case (state_q)
      StIdle: begin
        if (acc_in && action_i == ActLocal && row_index_i == 2'd3) begin
          state_d = is_root ? StMac : StLoad;
        end
      end
      StLoad: begin
        if (rd_pend_q && ei_q == 4'd12) state_d = StMac;
      end
      StMac: begin
        mac_a = loc_q[{er, 2'b00} - {2'b00, er} + {2'b00, k_q}];
        mac_b = par_q[ki_par];
        if (k_q == 2'd0) begin
          mac_clr = 1'b1;
          mac_init = (er == 2'd3) ? par_q[4'd9 + {2'b0, ec}] : '0;
        end
        mac_en = 1'b1;
        if (rd_pend_q && ei_q == 4'd11) state_d = off_pend_q ? StOffset : StStore;
      end
      StOffset: begin
        mac_a = off_q[k_q];
        mac_b = g_q[ki_par];
        if (k_q == 2'd0) begin
          mac_clr = 1'b1;
          mac_init = g_q[4'd9 + {2'b0, ec}];
        end
        mac_en = 1'b1;
        if (rd_pend_q && ei_q == 4'd11) state_d = StStore;
      end
      StStore: begin
        if (ei_q == 4'd11) state_d = StEmit;
      end
      StEmit: begin
        mac_a = scl_q[orow_q];
        mac_b = g_q[{orow_q, 2'b00} - {2'b00, orow_q} + {2'b00, oc_q}];
        mac_clr = 1'b1;
        if (valid_o && !stall_i && orow_q == 2'd3) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  logic signed [31:0] scaled_q [3];
  logic emit_rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      off_pend_q <= 1'b0;
      scl_pend_q <= 1'b0;
      for (int i = 0; i < 12; i++) base_q[i] <= '0;
      base_q[0] <= 32'sd1 <<< FracBits;
      base_q[4] <= 32'sd1 <<< FracBits;
      base_q[8] <= 32'sd1 <<< FracBits;
      for (int i = 0; i < 3; i++) begin
        off_q[i] <= '0;
        scl_q[i] <= '0;
      end
      ei_q <= '0;
      k_q <= '0;
      rd_pend_q <= 1'b0;
      orow_q <= '0;
      oc_q <= '0;
      emit_rdy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          ei_q <= '0;
          k_q <= '0;
          rd_pend_q <= 1'b0;
          orow_q <= '0;
          oc_q <= '0;
          emit_rdy_q <= 1'b0;
          if (acc_in) begin
            case (action_i)
              ActBase: begin
                base_q[{row_index_i, 2'b00} - {2'b00, row_index_i}] <= elem_x_i;
                base_q[{row_index_i, 2'b00} - {2'b00, row_index_i} + 4'd1] <= elem_y_i;
                base_q[{row_index_i, 2'b00} - {2'b00, row_index_i} + 4'd2] <= elem_z_i;
              end
              ActOffset: begin
                off_q[0] <= elem_x_i; off_q[1] <= elem_y_i; off_q[2] <= elem_z_i;
                off_pend_q <= 1'b1;
              end
              ActScale: begin
                scl_q[0] <= elem_x_i; scl_q[1] <= elem_y_i; scl_q[2] <= elem_z_i;
                scl_pend_q <= 1'b1;
              end
              default: begin
                loc_q[{row_index_i, 2'b00} - {2'b00, row_index_i}] <= elem_x_i;
                loc_q[{row_index_i, 2'b00} - {2'b00, row_index_i} + 4'd1] <= elem_y_i;
                loc_q[{row_index_i, 2'b00} - {2'b00, row_index_i} + 4'd2] <= elem_z_i;
                bone_q <= bone_index_i;
                par_idx_q <= BoneW'(parent_index_i[7:0]);
                store_ok_q <= 1'b1;
                if (row_index_i == 2'd3 && is_root) begin
                  for (int i = 0; i < 12; i++) par_q[i] <= base_q[i];
                end
              end
            endcase
          end
        end
        StLoad: begin
          rd_pend_q <= 1'b1;
          if (rd_pend_q) par_q[ei_q - 4'd1] <= rd_q;
          if (ei_q != 4'd12) ei_q <= ei_q + 4'd1;
          if (rd_pend_q && ei_q == 4'd12) begin
            ei_q <= '0;
            rd_pend_q <= 1'b0;
          end
        end
        StMac, StOffset: begin
          // k runs 0..2, then a commit step (rd_pend_q used as commit flag)
          if (k_q == 2'd2 && !rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else if (rd_pend_q) begin
            g_q[ei_q] <= sat32(acc);
            rd_pend_q <= 1'b0;
            k_q <= '0;
            if (ei_q == 4'd11) ei_q <= (state_q == StMac && off_pend_q) ? 4'd9 : 4'd0;
            else ei_q <= ei_q + 4'd1;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        StStore: begin
          ei_q <= (ei_q == 4'd11) ? 4'd0 : ei_q + 4'd1;
        end
        StEmit: begin
          if (!emit_rdy_q) begin
            if (orow_q == 2'd3 || !scl_pend_q) begin
              for (int c = 0; c < 3; c++)
                scaled_q[c] <= g_q[{orow_q, 2'b00} - {2'b00, orow_q} + 4'(c)];
              emit_rdy_q <= 1'b1;
            end else begin
              scaled_q[oc_q] <= sat32(66'(mac_prod));
              if (oc_q == 2'd2) begin
                oc_q <= '0;
                emit_rdy_q <= 1'b1;
              end else oc_q <= oc_q + 2'd1;
            end
          end else if (!stall_i) begin
            emit_rdy_q <= 1'b0;
            orow_q <= orow_q + 2'd1;
            if (orow_q == 2'd3) begin
              off_pend_q <= 1'b0;
              scl_pend_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign valid_o = (state_q == StEmit) && emit_rdy_q;
  assign out_bone_o = bone_q;
  assign out_row_o = orow_q;
  assign out_x_o = scaled_q[0];
  assign out_y_o = scaled_q[1];
  assign out_z_o = scaled_q[2];
  assign last_row_o = (orow_q == 2'd3);

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> stall_o) else $error("accept while busy");
  a_valid_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == StEmit)) else $error("valid outside emit");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && last_row_o) |=> (state_q == StIdle))
    else $error("no return to idle");
`endif
endmodule
